>>> rtl/ltdd_pkg.sv
package ltdd_pkg;

	// Action codes carried in a request word.
	localparam logic [1:0] ACT_CHECK  = 2'd0;
	localparam logic [1:0] ACT_LOCK   = 2'd1;
	localparam logic [1:0] ACT_UNLOCK = 2'd2;

	// Status codes carried in a response word.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_DEADLOCK = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	typedef logic [1:0] action_t;
	typedef logic [1:0] status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_DECIDE,
		ST_EXPAND,
		ST_PICK,
		ST_LOAD,
		ST_DONE
	} state_t;

endpackage

>>> rtl/ltdd_channels.sv
// Request channel: one lock action by one thread.
interface ltdd_req_if #(
	parameter int LOCK_ID_BITS   = 16,
	parameter int THREAD_ID_BITS = 8
);
	logic                      valid;
	logic                      ready;
	ltdd_pkg::action_t         action;
	logic [LOCK_ID_BITS-1:0]   lock_id;
	logic [THREAD_ID_BITS-1:0] thread_id;

	modport source (output valid, action, lock_id, thread_id, input ready);
	modport sink (input valid, action, lock_id, thread_id, output ready);
endinterface

// Response channel: one status word per request.
interface ltdd_rsp_if;
	logic              valid;
	logic              ready;
	ltdd_pkg::status_t status;

	modport source (output valid, status, input ready);
	modport sink (input valid, status, output ready);
endinterface

// Configuration channel: writes the enable register.
interface ltdd_cfg_if;
	logic valid;
	logic ready;
	logic detector_enabled;

	modport source (output valid, detector_enabled, input ready);
	modport sink (input valid, detector_enabled, output ready);
endinterface

>>> rtl/lock_table_deadlock_detect_top.sv
// Channel | Modport | Word contents                        | Accepted when
// req     | sink    | action, lock_id, thread_id           | req.valid & req.ready
// rsp     | source  | status                               | rsp.valid & rsp.ready
// cfg     | sink    | detector_enabled                     | cfg.valid & cfg.ready
//
// An enabled request with a valid action takes a scan of all N = TABLE_ENTRIES entries,
// a decide and a done state; any other request goes straight to done. A check that
// starts a walk adds a scan, then per expanded owner a pick sweep of up to N entries,
// a load state, a scan and one last pick state; the entry RAM has a single read port.
// Reset clears the enable register, all entry valid bits and the response valid flag.
// A finished status waits in the response register while the next request is taken.
module lock_table_deadlock_detect_top #(
	parameter int TABLE_ENTRIES  = 16,
	parameter int THREAD_ID_BITS = 8,
	parameter int LOCK_ID_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ltdd_req_if.sink    req,
	ltdd_rsp_if.source  rsp,
	ltdd_cfg_if.sink    cfg
);
	import ltdd_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int TW = THREAD_ID_BITS;
	localparam int LW = LOCK_ID_BITS;
	localparam int WW = LW + 2 * TW;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	state_t state_q, state_d;

	logic                     enabled_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] visited_q;
	logic [TABLE_ENTRIES-1:0] pending_q;
	logic                     scan_run_q;
	logic                     cmp_vld_s1;
	logic                     found_q;
	logic                     free_found_q;
	logic                     rsp_valid_q;

	action_t        act_q;
	logic [LW-1:0]  lk_q;
	logic [TW-1:0]  tid_q;
	logic [IW-1:0]  scan_addr_q;
	logic [IW-1:0]  cmp_idx_s1;
	logic [IW-1:0]  ent_idx_q;
	logic [TW-1:0]  ent_owner_q;
	logic [TW-1:0]  ent_waiter_q;
	logic [IW-1:0]  free_idx_q;
	logic [TW-1:0]  target_q;
	logic [IW-1:0]  pick_q;
	status_t        status_q;
	status_t        rsp_status_q;

	logic           rd_en;
	logic [IW-1:0]  rd_addr;
	logic [WW-1:0]  rd_data;
	logic           wr_en;
	logic [IW-1:0]  wr_addr;
	logic [WW-1:0]  wr_data;

	logic [LW-1:0]  rd_lock;
	logic [TW-1:0]  rd_owner;
	logic [TW-1:0]  rd_waiter;

	logic req_take;
	logic rsp_free;
	logic scan_last;
	logic find_hit;
	logic exp_hit;
	logic exp_dead;
	logic check_go;
	logic alloc;
	logic pick_hit;
	logic load_rsp;

	// Entry words are {lock, owner, waiter}.
	ltdd_ram #(
		.WIDTH(WW),
		.DEPTH(TABLE_ENTRIES)
	) u_entries (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_lock   = rd_data[WW-1 -: LW];
	assign rd_owner  = rd_data[2*TW-1 -: TW];
	assign rd_waiter = rd_data[TW-1:0];

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;

	assign req_take = req.valid && (state_q == ST_IDLE);
	assign rsp_free = !rsp_valid_q || rsp.ready;

	// Compare stage conditions on the word read in the previous cycle.
	assign scan_last = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
	assign find_hit  = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rd_lock == lk_q);
	assign exp_hit   = (state_q == ST_EXPAND) && cmp_vld_s1 && valid_q[cmp_idx_s1] &&
		!visited_q[cmp_idx_s1] && (rd_waiter == target_q);
	assign exp_dead  = exp_hit && (rd_owner == tid_q);
	assign check_go  = found_q && (ent_owner_q != '0) && (ent_owner_q != tid_q);
	assign alloc     = (state_q == ST_DECIDE) && (act_q == ACT_LOCK) && !found_q &&
		free_found_q;
	assign pick_hit  = (state_q == ST_PICK) && (pending_q != '0) && pending_q[pick_q];
	assign load_rsp  = (state_q == ST_DONE) && rsp_free;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (enabled_q && (req.action == ACT_CHECK || req.action == ACT_LOCK ||
						req.action == ACT_UNLOCK)) begin
						state_d = ST_FIND;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FIND: begin
				if (scan_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (act_q == ACT_CHECK && check_go) begin
					state_d = ST_EXPAND;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_EXPAND: begin
				if (exp_dead) begin
					state_d = ST_DONE;
				end else if (scan_last) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (pending_q == '0) begin
					state_d = ST_DONE;
				end else if (pending_q[pick_q]) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_EXPAND;
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// RAM port control for each state.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_addr_q;
		wr_en   = 1'b0;
		wr_addr = ent_idx_q;
		wr_data = {lk_q, ent_owner_q, tid_q};
		unique case (state_q)
			ST_FIND, ST_EXPAND: begin
				rd_en = scan_run_q;
			end
			ST_PICK: begin
				rd_en   = pick_hit;
				rd_addr = pick_q;
			end
			ST_DECIDE: begin
				priority if (act_q == ACT_CHECK) begin
					wr_en = check_go;
				end else if (act_q == ACT_LOCK && found_q) begin
					wr_en   = 1'b1;
					wr_data = {lk_q, tid_q, (ent_waiter_q == tid_q) ? TW'(0) : ent_waiter_q};
				end else if (act_q == ACT_LOCK) begin
					wr_en   = free_found_q;
					wr_addr = free_idx_q;
					wr_data = {lk_q, tid_q, TW'(0)};
				end else begin
					wr_en = 1'b0;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Control state, table valid bits and walk bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			enabled_q    <= 1'b0;
			valid_q      <= '0;
			visited_q    <= '0;
			pending_q    <= '0;
			scan_run_q   <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				enabled_q <= cfg.detector_enabled;
			end

			// The scan issues addresses 0 to N-1; each compare is made in the cycle after its read.
			cmp_vld_s1 <= rd_en && (state_q != ST_PICK) && !exp_dead;
			if ((scan_run_q && rd_en && scan_addr_q == LAST_IDX) || exp_dead) begin
				scan_run_q <= 1'b0;
			end
			if (state_d == ST_FIND && state_q == ST_IDLE) begin
				scan_run_q   <= 1'b1;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (state_q == ST_LOAD ||
				(state_q == ST_DECIDE && state_d == ST_EXPAND)) begin
				scan_run_q <= 1'b1;
			end

			// Lookup of the lock and of the lowest free entry.
			if (state_q == ST_FIND) begin
				if (find_hit && !found_q) begin
					found_q <= 1'b1;
				end
				if (cmp_vld_s1 && !valid_q[cmp_idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end

			// Table update.
			if (alloc) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (state_q == ST_DECIDE && act_q == ACT_UNLOCK && found_q) begin
				valid_q[ent_idx_q] <= 1'b0;
			end

			// Walk: mark reached entries and queue their owners for expansion.
			if (state_q == ST_DECIDE) begin
				visited_q <= '0;
				pending_q <= '0;
			end
			if (exp_hit) begin
				visited_q[cmp_idx_s1] <= 1'b1;
				if (rd_owner != '0 && !exp_dead) begin
					pending_q[cmp_idx_s1] <= 1'b1;
				end
			end
			if (pick_hit) begin
				pending_q[pick_q] <= 1'b0;
			end

			// Response register.
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req_take) begin
			act_q    <= req.action;
			lk_q     <= req.lock_id;
			tid_q    <= req.thread_id;
			status_q <= STAT_OK;
		end
		if (rd_en && state_q != ST_PICK) begin
			scan_addr_q <= scan_addr_q + IW'(1);
		end
		cmp_idx_s1 <= scan_addr_q;
		if ((state_q == ST_IDLE) || (state_q == ST_LOAD) || (state_q == ST_DECIDE)) begin
			scan_addr_q <= '0;
		end
		if (state_q == ST_FIND) begin
			if (find_hit && !found_q) begin
				ent_idx_q    <= cmp_idx_s1;
				ent_owner_q  <= rd_owner;
				ent_waiter_q <= rd_waiter;
			end
			if (cmp_vld_s1 && !valid_q[cmp_idx_s1] && !free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			target_q <= ent_owner_q;
			pick_q   <= '0;
			if (act_q == ACT_LOCK && !found_q && !free_found_q) begin
				status_q <= STAT_FULL;
			end
		end
		if (exp_dead) begin
			status_q <= STAT_DEADLOCK;
		end
		if (state_q == ST_PICK && pending_q != '0 && !pending_q[pick_q]) begin
			pick_q <= (pick_q == LAST_IDX) ? '0 : pick_q + IW'(1);
		end
		if (state_q == ST_LOAD) begin
			target_q <= rd_owner;
		end
		if (load_rsp) begin
			rsp_status_q <= status_q;
		end
	end

`ifndef ASSERT_OFF
	// An entry queued for expansion has always been reached first.
	a_pending_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q & ~visited_q) == '0)
		else $error("pending entry not marked visited");

	// A new lock is only placed into an entry that was free.
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |-> !valid_q[free_idx_q])
		else $error("allocation into a valid entry");

	// Deadlock can only come out of a check request.
	a_dead_check: assert property (@(posedge clk) disable iff (!arst_n)
		(load_rsp && status_q == STAT_DEADLOCK) |-> (act_q == ACT_CHECK))
		else $error("deadlock reported for a non-check request");

	// A taken request keeps the sequencer busy in the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> !req.ready)
		else $error("request accepted on consecutive cycles");
`endif

endmodule

>>> rtl/ltdd_ram.sv
module ltdd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
